FILE: rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

  // Default and limits of the line store depth
  localparam int unsigned MaxRowLength = 1024;
  localparam int unsigned MinRowLength = 3;

  // Row length register: width and value after reset
  localparam int unsigned RowLengthWidth = 11;
  localparam logic [RowLengthWidth-1:0] RowLengthReset = 11'd640;

  // Pixel and result widths
  localparam int unsigned PixelWidth = 8;
  localparam int unsigned RootWidth  = 8;

  // Window rows needed before a window lies inside the image
  localparam logic [1:0] RowsFull = 2'd2;

  // Per-pixel sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_GRAD,
    S_SQR,
    S_ROOT,
    S_DONE
  } sem_state_e;

endpackage

FILE: rtl/sobel_edge_magnitude_unit.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream, with line store memory.
//
// Usage: pixels enter on the input channel (in_valid_i/in_ready_o) in raster
// order, with frame_start_i high on the first pixel of each image. Each pixel
// gives exactly one result on the output channel (out_valid_o/out_ready_i):
// the floor of the Sobel gradient magnitude, saturated at 255, and a flag that
// the 3x3 window ending at that pixel lies inside the image (0 magnitude when
// not). The row length is written through the configuration channel
// (cfg_valid_i/cfg_ready_o, always ready) while the unit is idle.
// Throughput: one pixel at a time; the next pixel is accepted only after the
// previous result has been handed off. A pixel with a window inside the image
// passes line store read-modify-write, kernel sums, squares, 8 square-root steps
// and hand-off; when the magnitude saturates the square-root steps are skipped,
// and a pixel at the image border goes from the line store read-modify-write
// straight to hand-off. The square root is bit-serial.
// Both line stores share one 16-bit wide memory, read at acceptance and
// written back in the following cycle.
// Reset clears the window, column and row counts and sets the row length to
// 640; the line store memory is not cleared. When the receiver stalls, the
// result waits in the output register; the next pixel is still accepted and
// processed, and holds in its final state until the output register frees.
module sobel_edge_magnitude_unit #(
  parameter int unsigned MAX_ROW_LENGTH = sem_pkg::MaxRowLength
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sem_pkg::RowLengthWidth-1:0]   row_length_i,
  // pixel request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sem_pkg::PixelWidth-1:0]       pixel_i,
  input  logic                                 frame_start_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sem_pkg::RootWidth-1:0]        magnitude_o,
  output logic                                 window_valid_o
);

  import sem_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_ROW_LENGTH);
  localparam int unsigned LW   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned CMPW = (LW > RowLengthWidth) ? LW : RowLengthWidth;
  localparam int unsigned MW   = 2 * PixelWidth;
  localparam int unsigned SW   = PixelWidth + 2;   // one side of a kernel sum
  localparam int unsigned QW   = 2 * SW;           // one square
  localparam int unsigned TW   = QW + 1;           // sum of squares
  localparam int unsigned BW   = $clog2(RootWidth);

  sem_state_e state_q, state_d;

  logic [RowLengthWidth-1:0] row_length_q;
  logic [CW-1:0]             colcnt_q, colcnt_d;
  logic [1:0]                rows_q, rows_d;

  logic [PixelWidth-1:0]     px_q;
  logic [CW-1:0]             col_q;
  logic                      wvalid_q;
  logic [PixelWidth-1:0]     win_q [9];

  logic [MW-1:0]             mem [MAX_ROW_LENGTH];
  logic [MW-1:0]             rdata_q;

  logic [SW-1:0]             absx_q, absy_q;
  logic [TW-1:0]             sq_sum;
  logic [MW-1:0]             sum_lo_q;
  logic                      sat_q;
  logic [RootWidth-1:0]      root_q;
  logic [BW-1:0]             bit_q;

  logic                      out_valid_q;
  logic [RootWidth-1:0]      mag_q;
  logic                      wv_out_q;

  logic                      accept;
  logic                      mem_we;
  logic                      load_out;

  // Configuration port never stalls
  assign cfg_ready_o = 1'b1;

  // Hold the row length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RowLengthReset;
    end else if (cfg_valid_i) begin
      row_length_q <= row_length_i;
    end
  end

  // Clamp the row length into the supported range
  logic [CMPW-1:0] len_wide;
  logic [LW-1:0]   len;
  always_comb begin
    len_wide = CMPW'(row_length_q);
    if (len_wide < CMPW'(MinRowLength)) begin
      len_wide = CMPW'(MinRowLength);
    end else if (len_wide > CMPW'(MAX_ROW_LENGTH)) begin
      len_wide = CMPW'(MAX_ROW_LENGTH);
    end
    len = LW'(len_wide);
  end

  // Resolve the column and row position of the incoming pixel
  logic [CW-1:0] col_base, col_now;
  logic [1:0]    rows_base;
  logic [LW-1:0] col_next;
  logic          row_end, wvalid_now;
  always_comb begin
    col_base  = frame_start_i ? '0 : colcnt_q;
    rows_base = frame_start_i ? '0 : rows_q;
    col_now   = (LW'(col_base) >= len) ? '0 : col_base;
    col_next  = LW'(col_now) + LW'(1);
    row_end   = (col_next >= len);
    wvalid_now = (rows_base == RowsFull) && (col_now >= CW'(2));
    colcnt_d  = row_end ? '0 : CW'(col_next);
    rows_d    = (row_end && (rows_base != RowsFull)) ? rows_base + 2'd1 : rows_base;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_WIN;
      S_WIN:  state_d = wvalid_q ? S_GRAD : S_DONE;
      S_GRAD: state_d = S_SQR;
      S_SQR:  state_d = (sq_sum[TW-1:MW] != '0) ? S_DONE : S_ROOT;
      S_ROOT: if (bit_q == '0) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Decode the control outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_WIN:   mem_we     = 1'b1;
      S_DONE:  load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Advance the sequencer and the position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      colcnt_q <= '0;
      rows_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        colcnt_q <= colcnt_d;
        rows_q   <= rows_d;
      end
    end
  end

  // Line store memory: older row in the upper byte, newer row in the lower
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[col_q] <= {rdata_q[PixelWidth-1:0], px_q};
    end
    if (accept) begin
      rdata_q <= mem[col_now];
    end
  end

  // Capture the pixel request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q     <= pixel_i;
      col_q    <= col_now;
      wvalid_q <= wvalid_now;
    end
  end

  // Shift the window one column left and insert the new right column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (mem_we) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= rdata_q[MW-1:PixelWidth];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= rdata_q[PixelWidth-1:0];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= px_q;
    end
  end

  // Kernel sums: Gx right minus left column, Gy bottom minus top row
  logic [SW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  always_comb begin
    gx_pos = SW'(win_q[2]) + SW'({win_q[5], 1'b0}) + SW'(win_q[8]);
    gx_neg = SW'(win_q[0]) + SW'({win_q[3], 1'b0}) + SW'(win_q[6]);
    gy_pos = SW'(win_q[6]) + SW'({win_q[7], 1'b0}) + SW'(win_q[8]);
    gy_neg = SW'(win_q[0]) + SW'({win_q[1], 1'b0}) + SW'(win_q[2]);
  end

  // Square and sum, then one root bit per cycle
  logic [RootWidth-1:0] trial;
  logic [MW-1:0]        trial_sq;
  always_comb begin
    sq_sum   = TW'(QW'(absx_q) * QW'(absx_q)) + TW'(QW'(absy_q) * QW'(absy_q));
    trial    = root_q | RootWidth'(1 << bit_q);
    trial_sq = MW'(trial) * MW'(trial);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_WIN: begin
        root_q <= '0;
      end
      S_GRAD: begin
        absx_q <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        absy_q <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      end
      S_SQR: begin
        sat_q    <= (sq_sum[TW-1:MW] != '0);
        sum_lo_q <= sq_sum[MW-1:0];
        bit_q    <= BW'(RootWidth - 1);
        root_q   <= (sq_sum[TW-1:MW] != '0) ? '1 : '0;
      end
      S_ROOT: begin
        if (!sat_q && (trial_sq <= sum_lo_q)) begin
          root_q <= trial;
        end
        bit_q <= bit_q - BW'(1);
      end
      default: ;
    endcase
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mag_q    <= root_q;
      wv_out_q <= wvalid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign magnitude_o    = mag_q;
  assign window_valid_o = wv_out_q;

endmodule
